/* rtl/smc_pkg.sv */
`default_nettype none

package smc_pkg;

  // Fixed field widths of the request and configuration port
  localparam int unsigned IdxW     = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // Request kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLS_IN_USE = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_EMIT
  } smc_state_e;

endpackage

`default_nettype wire

/* rtl/smc_if.sv */
`default_nettype none

interface smc_req_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [smc_pkg::IdxW-1:0]    row_index;
  logic [smc_pkg::IdxW-1:0]    col_index;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, action, row_index, col_index, value, input ready);
  modport sink   (input valid, action, row_index, col_index, value, output ready);
endinterface

interface smc_rsp_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink   (input valid, found, output ready);
endinterface

`default_nettype wire

/* rtl/smc_store.sv */
`default_nettype none

// Single-port-write, single-port-read word store with registered read data.
module smc_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/sorted_matrix_search_core.sv */
`default_nettype none

// Sorted matrix search core.
// Holds a MAX_ROWS x MAX_COLS matrix of signed words in one synchronous memory.
// Requests arrive on req_if (valid/ready). A load request writes one entry at
// (row_index, col_index) and gives no response; out-of-range loads are dropped.
// A query request carries a key in value: the core binary-searches column 0 for
// the last row whose first word is at or below the key, then binary-searches
// that row, and returns one response on rsp_if with found set on a hit.
// Each query probe is one memory read whose registered data is compared in the
// next cycle while the next address is issued.
// Only one request is in flight; req_if.ready is high while the sequencer idles.
// A finished response sits in an output register, so the next request is taken
// while the receiver stalls; if a second response finishes before the first is
// taken, the core holds it and waits. Reset clears the sequencer, the response
// register and rows_in_use/cols_in_use; matrix contents are undefined until
// loaded, and no clearing pass runs.
module sorted_matrix_search_core #(
  parameter int unsigned MAX_ROWS   = 32,
  parameter int unsigned MAX_COLS   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  smc_req_if.sink                             req_if,
  smc_rsp_if.source                           rsp_if,
  input  wire logic                           cfg_we_i,
  input  wire logic [smc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [smc_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Row bounds run 0..MAX_ROWS, column bounds -1..MAX_COLS
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned CSW   = CW + 1;

  // Configuration registers
  logic [smc_pkg::CfgDataW-1:0] rows_in_use_q, rows_in_use_d;
  logic [smc_pkg::CfgDataW-1:0] cols_in_use_q, cols_in_use_d;

  // Sequencer
  smc_pkg::smc_state_e state_q, state_d;
  logic signed [DATA_WIDTH-1:0] key_q, key_d;
  logic [RW-1:0]        row_lo_q, row_lo_d, row_hi_q, row_hi_d, row_mid_q, row_mid_d;
  logic [RW-1:0]        row_sel_q, row_sel_d;
  logic signed [CSW-1:0] col_lo_q, col_lo_d, col_hi_q, col_hi_d, col_mid_q, col_mid_d;
  logic                 pend_q, pend_d;

  // Response register
  logic rsp_valid_q, rsp_valid_d;
  logic found_q, found_d;

  // Memory port
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [RW-1:0]         rd_row;
  logic [CW-1:0]         rd_col;

  // Combinational helpers
  logic                  req_acc, slot_free, fin, fin_found;
  logic [RW-1:0]         rows_eff, row_lo_n, row_hi_n;
  logic [RW:0]           row_sum;
  logic [CW-1:0]         cols_eff;
  logic signed [CSW-1:0] col_lo_n, col_hi_n;
  logic [CSW:0]          col_sum;
  logic                  row_le, col_eq, col_gt;

  function automatic logic [AW-1:0] entry_addr(logic [AW-1:0] r, logic [AW-1:0] c);
    return AW'(r * AW'(MAX_COLS) + c);
  endfunction

  assign req_acc   = req_if.valid && req_if.ready;
  assign slot_free = !rsp_valid_q || rsp_if.ready;
  assign req_if.ready = (state_q == smc_pkg::ST_IDLE);

  // Clamp the counts in use to the matrix size
  assign rows_eff = (32'(rows_in_use_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_in_use_q);
  assign cols_eff = (32'(cols_in_use_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_in_use_q);

  // Load path: write at acceptance, drop out-of-range entries
  assign mem_we    = req_acc && (req_if.action == smc_pkg::ACT_LOAD)
                     && (32'(req_if.row_index) < MAX_ROWS)
                     && (32'(req_if.col_index) < MAX_COLS);
  assign mem_waddr = entry_addr(AW'(req_if.row_index), AW'(req_if.col_index));
  assign mem_raddr = entry_addr(AW'(rd_row), AW'(rd_col));

  // Probe compares against the registered read data
  assign row_le = $signed(mem_rdata) <= key_q;
  assign col_eq = $signed(mem_rdata) == key_q;
  assign col_gt = $signed(mem_rdata) >  key_q;

  always_comb begin
    cols_in_use_d = cols_in_use_q;
    rows_in_use_d = rows_in_use_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smc_pkg::CFG_ROWS_IN_USE: rows_in_use_d = cfg_data_i;
        smc_pkg::CFG_COLS_IN_USE: cols_in_use_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    row_lo_d  = row_lo_q;
    row_hi_d  = row_hi_q;
    row_mid_d = row_mid_q;
    row_sel_d = row_sel_q;
    col_lo_d  = col_lo_q;
    col_hi_d  = col_hi_q;
    col_mid_d = col_mid_q;
    pend_d    = pend_q;
    mem_re    = 1'b0;
    rd_row    = '0;
    rd_col    = '0;
    fin       = 1'b0;
    fin_found = 1'b0;
    row_lo_n  = row_lo_q;
    row_hi_n  = row_hi_q;
    row_sum   = '0;
    col_lo_n  = col_lo_q;
    col_hi_n  = col_hi_q;
    col_sum   = '0;

    unique case (state_q)
      smc_pkg::ST_IDLE: begin
        if (req_acc && (req_if.action == smc_pkg::ACT_QUERY)) begin
          key_d = req_if.value;
          if ((rows_eff == '0) || (cols_eff == '0)) begin
            fin = 1'b1;
          end else begin
            // First row probe at rows/2 of column 0
            row_lo_d  = '0;
            row_hi_d  = rows_eff;
            row_mid_d = rows_eff >> 1;
            mem_re    = 1'b1;
            rd_row    = rows_eff >> 1;
            state_d   = smc_pkg::ST_ROW;
          end
        end
      end

      smc_pkg::ST_ROW: begin
        row_lo_n = row_le ? RW'(row_mid_q + 1'b1) : row_lo_q;
        row_hi_n = row_le ? row_hi_q : row_mid_q;
        row_sum  = (RW+1)'(row_lo_n) + (RW+1)'(row_hi_n);
        row_lo_d = row_lo_n;
        row_hi_d = row_hi_n;
        if (row_lo_n < row_hi_n) begin
          // Issue the next probe in the same cycle
          row_mid_d = RW'(row_sum >> 1);
          mem_re    = 1'b1;
          rd_row    = RW'(row_sum >> 1);
        end else if (row_lo_n == '0) begin
          // Key lies below every row
          fin = 1'b1;
        end else begin
          row_sel_d = RW'(row_lo_n - 1'b1);
          col_lo_d  = '0;
          col_hi_d  = CSW'(cols_eff) - CSW'(1);
          col_mid_d = CSW'((cols_eff - 1'b1) >> 1);
          mem_re    = 1'b1;
          rd_row    = RW'(row_lo_n - 1'b1);
          rd_col    = CW'((cols_eff - 1'b1) >> 1);
          state_d   = smc_pkg::ST_COL;
        end
      end

      smc_pkg::ST_COL: begin
        col_lo_n = col_lo_q;
        col_hi_n = col_hi_q;
        if (col_gt) begin
          col_hi_n = col_mid_q - CSW'(1);
        end else begin
          col_lo_n = col_mid_q + CSW'(1);
        end
        col_sum  = (CSW+1)'($unsigned(col_lo_n)) + (CSW+1)'($unsigned(col_hi_n));
        col_lo_d = col_lo_n;
        col_hi_d = col_hi_n;
        if (col_eq) begin
          fin       = 1'b1;
          fin_found = 1'b1;
        end else if (col_lo_n <= col_hi_n) begin
          col_mid_d = CSW'(col_sum >> 1);
          mem_re    = 1'b1;
          rd_row    = row_sel_q;
          rd_col    = CW'(col_sum >> 1);
        end else begin
          fin = 1'b1;
        end
      end

      smc_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_d = smc_pkg::ST_IDLE;
        end
      end
    endcase

    if (fin) begin
      // Hold the answer if the response register is still occupied
      pend_d  = fin_found;
      state_d = slot_free ? smc_pkg::ST_IDLE : smc_pkg::ST_EMIT;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_if.ready;
    found_d     = found_q;
    if (fin && slot_free) begin
      rsp_valid_d = 1'b1;
      found_d     = fin_found;
    end else if ((state_q == smc_pkg::ST_EMIT) && slot_free) begin
      rsp_valid_d = 1'b1;
      found_d     = pend_q;
    end
  end

  assign rsp_if.valid = rsp_valid_q;
  assign rsp_if.found = found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= smc_pkg::ST_IDLE;
      rsp_valid_q   <= 1'b0;
      rows_in_use_q <= '0;
      cols_in_use_q <= '0;
    end else begin
      state_q       <= state_d;
      rsp_valid_q   <= rsp_valid_d;
      rows_in_use_q <= rows_in_use_d;
      cols_in_use_q <= cols_in_use_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    row_lo_q  <= row_lo_d;
    row_hi_q  <= row_hi_d;
    row_mid_q <= row_mid_d;
    row_sel_q <= row_sel_d;
    col_lo_q  <= col_lo_d;
    col_hi_q  <= col_hi_d;
    col_mid_q <= col_mid_d;
    pend_q    <= pend_d;
    found_q   <= found_d;
  end

  smc_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DATA_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (DATA_WIDTH'(req_if.value)),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Loads only land while the sequencer idles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == smc_pkg::ST_IDLE)
    else $error("load write outside idle");

  // A held answer only waits behind an occupied response register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smc_pkg::ST_EMIT |-> rsp_valid_q)
    else $error("pending answer with empty response register");

  // Row probe stays inside the half-open interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smc_pkg::ST_ROW |-> (row_lo_q <= row_mid_q) && (row_mid_q < row_hi_q))
    else $error("row probe out of bounds");

  // Column probe stays inside the closed interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smc_pkg::ST_COL |-> (col_lo_q <= col_mid_q) && (col_mid_q <= col_hi_q))
    else $error("column probe out of bounds");

endmodule

`default_nettype wire
